// ===== rtl/core/ffba_pkg.sv =====
// Shared types, constants and helper functions of the first-fit block allocator.
package ffba_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int MIN_POOL     = 24;
    localparam int RESET_POOL   = 8192;

    localparam int HDR_W = 15;
    localparam int POS_W = 12;

    typedef logic signed [HDR_W-1:0] hdr_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [13:0]             bytes_t;
    typedef logic [14:0]             need_t;
    typedef logic [12:0]             addr_t;
    typedef logic [1:0]              status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_SPACE = 2'd1;
    localparam status_t ST_BAD_FREE = 2'd2;

    localparam logic FUNC_FREE = 1'b1;

    typedef struct packed {
        logic   func;
        bytes_t req_bytes;
        addr_t  free_address;
    } op_t;

    typedef struct packed {
        status_t status;
        addr_t   payload_address;
        bytes_t  largest_free_bytes;
    } res_t;

    typedef struct packed {
        logic idle;
        logic clearing;
        logic done;
    } eng_stat_t;

    // Pool size aligned down to a header, raised to the minimum, limited to capacity.
    function automatic bytes_t clamp_pool(bytes_t raw, int unsigned cap);
        bytes_t b;
        b = {raw[13:3], 3'b000};
        if (b < bytes_t'(MIN_POOL))
            b = bytes_t'(MIN_POOL);
        if (32'(b) > cap)
            b = bytes_t'(cap);
        return b;
    endfunction

    // Number of header words spanned by a block of the given signed length.
    function automatic pos_t step_of(hdr_t s);
        logic signed [HDR_W:0] se;
        logic [HDR_W:0]        m;
        se = {s[HDR_W-1], s};
        m  = s[HDR_W-1] ? $unsigned(-se) : $unsigned(se);
        return m[POS_W+2:3];
    endfunction

    // Request rounded up to a header multiple, plus the header itself.
    function automatic need_t need_of(bytes_t req);
        need_t r7;
        r7 = need_t'(req) + need_t'(7);
        return {r7[14:3], 3'b000} + need_t'(HEADER_BYTES);
    endfunction

endpackage

// ===== rtl/core/ffba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ffba_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ffba_engine.sv =====
// Header walk sequencer: pool clearing, merge and measure, first fit, split and free.
module ffba_engine #(
    parameter int POOL_WORDS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ffba_pkg::op_t      op,
    input  logic               cfg_we,
    input  ffba_pkg::bytes_t   cfg_data,
    input  logic               out_free,
    output ffba_pkg::eng_stat_t stat,
    output ffba_pkg::res_t     res
);

    import ffba_pkg::*;

    localparam int AW = $clog2(POOL_WORDS);
    localparam int unsigned CAP = POOL_WORDS * HEADER_BYTES;
    localparam bytes_t RST_POOL = clamp_pool(bytes_t'(RESET_POOL), CAP);
    localparam bytes_t RST_BODY = RST_POOL - bytes_t'(2 * HEADER_BYTES);
    localparam pos_t   RST_END  = pos_t'(RST_BODY >> 3);
    localparam hdr_t   RST_BASE = hdr_t'(RST_BODY);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_PASS    = 4'd2;
    localparam logic [3:0] S_M_HEAD  = 4'd3;
    localparam logic [3:0] S_M_NEXT  = 4'd4;
    localparam logic [3:0] S_EVAL    = 4'd5;
    localparam logic [3:0] S_FIT     = 4'd6;
    localparam logic [3:0] S_SPLIT   = 4'd7;
    localparam logic [3:0] S_TAKE    = 4'd8;
    localparam logic [3:0] S_FREE_RD = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    pos_t          chain_end_reg, chain_end_next;
    hdr_t          base_reg, base_next;
    pos_t          w_reg, w_next;
    pos_t          t_reg, t_next;
    hdr_t          acc_reg, acc_next;
    need_t         largest_reg, largest_next;
    need_t         need_reg, need_next;
    status_t       status_reg, status_next;
    addr_t         payload_reg, payload_next;
    logic          pass_final_reg, pass_final_next;
    logic          walk_fit_reg, walk_fit_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    hdr_t          ram_wdata;
    logic [AW-1:0] ram_raddr;
    hdr_t          rd;
    logic          done;

    pos_t           rd_step;
    pos_t           w_adv;
    pos_t           t_adv;
    hdr_t           acc_sum;
    hdr_t           em_val;
    pos_t           em_nw;
    pos_t           em_step;
    need_t          lg_head;
    need_t          lg_em;
    pos_t           free_word;
    logic           free_bad;
    logic [POS_W:0] rest;
    bytes_t         cfg_pool;

    ffba_ram #(
        .WIDTH (HDR_W),
        .DEPTH (POOL_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    assign rd_step  = step_of(rd);
    assign w_adv    = w_reg + rd_step;
    assign t_adv    = t_reg + rd_step;
    assign acc_sum  = acc_reg + rd;
    assign em_val   = (rd > 0) ? acc_sum : acc_reg;
    assign em_step  = step_of(em_val);
    assign em_nw    = w_reg + em_step;
    assign lg_head  = ($unsigned(rd) > largest_reg) ? $unsigned(rd) : largest_reg;
    assign lg_em    = ($unsigned(em_val) > largest_reg) ? $unsigned(em_val) : largest_reg;
    assign free_word = pos_t'(op.free_address[12:3]) - pos_t'(1);
    assign free_bad  = (op.free_address[2:0] != 3'd0) || (op.free_address < addr_t'(HEADER_BYTES));
    assign rest      = {1'b0, w_reg} + {1'b0, need_reg[14:3]};
    assign cfg_pool  = clamp_pool(cfg_data, CAP);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        chain_end_next  = chain_end_reg;
        base_next       = base_reg;
        w_next          = w_reg;
        t_next          = t_reg;
        acc_next        = acc_reg;
        largest_next    = largest_reg;
        need_next       = need_reg;
        status_next     = status_reg;
        payload_next    = payload_reg;
        pass_final_next = pass_final_reg;
        walk_fit_next   = walk_fit_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        done            = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = (clr_cnt_reg == '0) ? base_reg : '0;
                if (clr_cnt_reg == AW'(POOL_WORDS - 1))
                    state_next = S_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + AW'(1);
            end

            S_IDLE:
            begin
                if (start)
                begin
                    need_next     = need_of(op.req_bytes);
                    status_next   = ST_OK;
                    payload_next  = '0;
                    walk_fit_next = 1'b0;
                    if (op.func != FUNC_FREE)
                    begin
                        pass_final_next = 1'b0;
                        state_next      = S_PASS;
                    end
                    else
                    begin
                        pass_final_next = 1'b1;
                        if (free_bad || free_word >= chain_end_reg)
                        begin
                            status_next = ST_BAD_FREE;
                            state_next  = S_PASS;
                        end
                        else
                        begin
                            w_next     = free_word;
                            ram_raddr  = AW'(free_word);
                            state_next = S_FREE_RD;
                        end
                    end
                end
            end

            S_FREE_RD:
            begin
                if (rd >= 0)
                    status_next = ST_BAD_FREE;
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(w_reg);
                    ram_wdata = -rd;
                end
                state_next = S_PASS;
            end

            // Every walk starts here so that a write of the previous cycle has landed.
            S_PASS:
            begin
                w_next    = '0;
                ram_raddr = '0;
                if (walk_fit_reg)
                    state_next = S_FIT;
                else
                begin
                    largest_next = '0;
                    state_next   = S_M_HEAD;
                end
            end

            S_M_HEAD:
            begin
                if (rd > 0)
                begin
                    if (rd_step == '0 || w_adv >= chain_end_reg)
                    begin
                        largest_next = lg_head;
                        state_next   = S_EVAL;
                    end
                    else
                    begin
                        acc_next   = rd;
                        t_next     = w_adv;
                        ram_raddr  = AW'(w_adv);
                        state_next = S_M_NEXT;
                    end
                end
                else if (rd_step == '0 || w_adv >= chain_end_reg)
                    state_next = S_EVAL;
                else
                begin
                    w_next    = w_adv;
                    ram_raddr = AW'(w_adv);
                end
            end

            S_M_NEXT:
            begin
                if (rd > 0 && rd_step != '0 && t_adv < chain_end_reg)
                begin
                    acc_next  = acc_sum;
                    t_next    = t_adv;
                    ram_raddr = AW'(t_adv);
                end
                else
                begin
                    // The free run ends here: store the merged length at its head.
                    ram_we       = 1'b1;
                    ram_waddr    = AW'(w_reg);
                    ram_wdata    = em_val;
                    largest_next = lg_em;
                    if (em_step == '0 || em_nw >= chain_end_reg)
                        state_next = S_EVAL;
                    else
                    begin
                        w_next     = em_nw;
                        ram_raddr  = AW'(em_nw);
                        state_next = S_M_HEAD;
                    end
                end
            end

            S_EVAL:
            begin
                if (pass_final_reg)
                    state_next = S_DONE;
                else
                begin
                    if (need_reg > largest_reg)
                    begin
                        status_next     = ST_NO_SPACE;
                        pass_final_next = 1'b1;
                    end
                    else
                        walk_fit_next = 1'b1;
                    state_next = S_PASS;
                end
            end

            S_FIT:
            begin
                if (rd > 0 && $unsigned(rd) >= need_reg)
                begin
                    acc_next   = rd;
                    state_next = S_SPLIT;
                end
                else if (rd_step == '0 || w_adv >= chain_end_reg)
                begin
                    status_next     = ST_NO_SPACE;
                    pass_final_next = 1'b1;
                    walk_fit_next   = 1'b0;
                    state_next      = S_PASS;
                end
                else
                begin
                    w_next    = w_adv;
                    ram_raddr = AW'(w_adv);
                end
            end

            S_SPLIT:
            begin
                if ($unsigned(acc_reg) > need_reg && 32'(rest) < POOL_WORDS)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(rest);
                    ram_wdata = acc_reg - hdr_t'(need_reg);
                end
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(w_reg);
                ram_wdata       = -hdr_t'(need_reg);
                payload_next    = addr_t'({w_reg + pos_t'(1), 3'b000});
                pass_final_next = 1'b1;
                walk_fit_next   = 1'b0;
                state_next      = S_PASS;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A pool write lays out a new pool and restarts the clearing sweep.
        if (cfg_we)
        begin
            chain_end_next = pos_t'((cfg_pool - bytes_t'(2 * HEADER_BYTES)) >> 3);
            base_next      = hdr_t'(cfg_pool - bytes_t'(2 * HEADER_BYTES));
            clr_cnt_next   = '0;
            state_next     = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            chain_end_reg  <= RST_END;
            base_reg       <= RST_BASE;
            pass_final_reg <= 1'b0;
            walk_fit_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            chain_end_reg  <= chain_end_next;
            base_reg       <= base_next;
            pass_final_reg <= pass_final_next;
            walk_fit_reg   <= walk_fit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        largest_reg <= largest_next;
        need_reg    <= need_next;
        status_reg  <= status_next;
        payload_reg <= payload_next;
    end

    assign stat.idle     = (state_reg == S_IDLE);
    assign stat.clearing = (state_reg == S_CLEAR);
    assign stat.done     = done;

    assign res.status             = status_reg;
    assign res.payload_address    = payload_reg;
    assign res.largest_free_bytes = largest_reg[13:0];

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// First-fit block allocator with free-block merging: ports, output register, checks.
//
//  Channel   Handshake                 Word
//  -------   ------------------------  -----------------------------------------------
//  cfg       cfg_valid / cfg_ready     pool_bytes
//  in        in_valid / in_stall       func, req_bytes, free_address
//  out       out_valid / out_stall     status, payload_address, largest_free_bytes
//
// Headers are visited one at a time through the header RAM's single read port.
// A new input word is taken only once the previous one has finished: a free walks
// the header chain once, an allocate up to three times (at most POOL_WORDS - 2 headers).
// Reset and every pool write start a clearing sweep of all POOL_WORDS words; in_stall is high.
// A finished word waits in the output register while the next input word is taken.
module first_fit_block_allocator #(
    parameter int POOL_WORDS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ffba_pkg::bytes_t    pool_bytes,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  ffba_pkg::bytes_t    req_bytes,
    input  ffba_pkg::addr_t     free_address,
    output logic                out_valid,
    input  logic                out_stall,
    output ffba_pkg::status_t   status,
    output ffba_pkg::addr_t     payload_address,
    output ffba_pkg::bytes_t    largest_free_bytes
);

    import ffba_pkg::*;

    eng_stat_t eng_stat;
    res_t      eng_res;
    op_t       op;
    logic      start;
    logic      cfg_we;
    logic      out_free;

    logic      out_valid_reg, out_valid_next;
    res_t      out_res_reg, out_res_next;

    assign cfg_ready = eng_stat.idle || eng_stat.clearing;
    assign cfg_we    = cfg_valid && cfg_ready;
    // A pending pool write wins over an input word in the same cycle.
    assign in_stall  = !eng_stat.idle || cfg_valid;
    assign start     = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign op.func         = func;
    assign op.req_bytes    = req_bytes;
    assign op.free_address = free_address;

    ffba_engine #(
        .POOL_WORDS (POOL_WORDS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (op),
        .cfg_we   (cfg_we),
        .cfg_data (pool_bytes),
        .out_free (out_free),
        .stat     (eng_stat),
        .res      (eng_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (eng_stat.done)
        begin
            out_valid_next = 1'b1;
            out_res_next   = eng_res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_res_reg.status;
    assign payload_address    = out_res_reg.payload_address;
    assign largest_free_bytes = out_res_reg.largest_free_bytes;

    // An accepted word keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in flight");

    // A pool write starts the clearing sweep, which holds off input words.
    a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall)
        else $error("input open right after a pool write");

    // Only a granted allocate carries a payload offset.
    a_fail_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> payload_address == '0)
        else $error("failed request reports a payload offset");

    // A granted offset always points past a header on a header boundary.
    a_payload_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_address != '0 |-> payload_address[2:0] == 3'd0)
        else $error("payload offset not header aligned");

endmodule
